[hdl/vcdd_pkg.sv]
package vcdd_pkg;

    localparam int WMASK_W     = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_TDATA_W = 136;

    localparam logic [15:0] THRESHOLD_RST  = 16'd256;
    localparam logic [4:0]  ESC_BASE_RST   = 5'd0;
    localparam logic [4:0]  ESC_COUNT_RST  = 5'd1;
    localparam logic [4:0]  ACTIVE_VCS_RST = 5'd16;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RECOVER = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_ESC_BASE   = 2'd1,
        REG_ESC_COUNT  = 2'd2,
        REG_ACTIVE_VCS = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_TICK     = 5'b00010,
        S_TICK_OUT = 5'b00100,
        S_COUNT    = 5'b01000,
        S_EMIT     = 5'b10000
    } state_t;

    // Packed so that the deadlock mask lands in the lowest bits of tdata.
    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] recovered_total;
        logic [31:0] detected_total;
        logic [31:0] tick_total;
        logic [4:0]  recovered_count;
        logic        escape_valid;
        logic [5:0]  escape_chan;
        logic [3:0]  vc_index;
        logic        deadlock_present;
        logic [15:0] deadlock_mask;
    } result_t;

endpackage

[hdl/vc_deadlock_timeout_detector_core.sv]
// Timeout deadlock detector for the virtual channels of a router port.
// Input stream (s_*): s_tuser is the command (0 = tick, 1 = recover) and
// s_tdata carries the waiting mask, one bit per channel. A tick updates the
// wait counter of every active channel and returns one result. A recover
// request returns one result per flagged active channel in ascending order,
// with the escape channel chosen for it; m_tlast marks the final one. A
// recover with no flagged channel returns nothing.
// Timing: a single counter/compare unit walks the channels one per cycle,
// pausing only while a result waits for the receiver. A tick walks every
// channel and then registers its result. A recover first walks all channels
// to count the flagged ones and then walks them again up to the last one,
// emitting at most one result per cycle. s_tready is high only while idle.
// The result sits in an output register; while the receiver stalls, the
// walk holds. A request can be accepted while the last result still waits
// in the output register.
// Reset (aresetn, synchronous) clears all counters, flags and totals and
// loads the configuration registers with their defaults.
module vc_deadlock_timeout_detector_core
    import vcdd_pkg::*;
#(
    parameter int NUM_VC      = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [WMASK_W-1:0]     s_tdata,   // [15:0] waiting_mask
    input  logic                   s_tuser,   // [0] command
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] deadlock_mask, [16] deadlock_present, [20:17] vc_index,
    // [26:21] escape_chan, [27] escape_valid, [32:28] recovered_count,
    // [64:33] tick_total, [96:65] detected_total, [128:97] recovered_total,
    // [135:129] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IDX_W = (NUM_VC > 1) ? $clog2(NUM_VC) : 1;
    localparam int CNT_W = $clog2(NUM_VC + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_VC - 1);
    localparam logic [5:0] NVC6 = 6'(NUM_VC);

    state_t state_reg, state_next;

    logic [15:0] threshold_reg;
    logic [4:0]  esc_base_reg;
    logic [4:0]  esc_count_reg;
    logic [4:0]  active_vcs_reg;

    logic [COUNT_WIDTH-1:0] count_mem [NUM_VC];
    logic [NUM_VC-1:0]      flag_mask_reg;
    logic [NUM_VC-1:0]      scan_reg;
    logic [WMASK_W-1:0]     wmask_reg;
    logic [31:0]            tick_total_reg;
    logic [31:0]            det_total_reg;
    logic [31:0]            rec_total_reg;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] found_reg;
    logic [CNT_W-1:0] k_reg;
    logic [4:0]       rem_reg;

    result_t result_reg;
    logic    m_tvalid_reg;
    logic    m_tlast_reg;

    logic [5:0]             eff_n;
    logic [5:0]             idx6;
    logic [IDX_W-1:0]       ch;
    logic                   ch_active;
    logic                   ch_wait;
    logic                   ch_flag;
    logic                   emit_now;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic                   hit;
    logic                   last_step;
    logic                   out_free;
    logic                   load_out;
    logic [4:0]             divisor;
    logic [4:0]             rem_inc;
    logic [4:0]             rem_next;
    logic [5:0]             esc_vc;
    logic [CNT_W-1:0]       k_inc;
    logic [CNT_W-1:0]       found_step;
    logic [31:0]            det_inc;

    assign eff_n     = ({1'b0, active_vcs_reg} > NVC6) ? NVC6 : {1'b0, active_vcs_reg};
    assign idx6      = 6'(idx_reg);
    assign ch        = idx_reg[IDX_W-1:0];
    assign ch_active = idx6 < eff_n;
    assign ch_wait   = (idx6 < 6'd16) && wmask_reg[idx6[3:0]];
    assign ch_flag   = scan_reg[ch];
    assign emit_now  = ch_active && ch_flag;

    // Shared unit: one saturating increment and one threshold compare.
    assign cur_count = count_mem[ch];
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
    assign hit       = 32'(inc_count) >= 32'(threshold_reg);

    assign last_step = idx_reg == LAST_IDX;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_out  = out_free &&
                       ((state_reg == S_TICK_OUT) || (state_reg == S_EMIT && emit_now));

    // The remainder of the channel index by the escape count runs along the walk.
    assign divisor  = (esc_count_reg == 5'd0) ? 5'd1 : esc_count_reg;
    assign rem_inc  = rem_reg + 5'd1;
    assign rem_next = (rem_inc == divisor) ? 5'd0 : rem_inc;
    assign esc_vc   = {1'b0, esc_base_reg} + {1'b0, rem_reg};

    assign k_inc      = k_reg + 1'b1;
    assign found_step = found_reg + CNT_W'(emit_now);
    assign det_inc    = det_total_reg + 32'(flag_mask_reg != '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == CMD_TICK) ? S_TICK : S_COUNT;
                end
            end
            S_TICK: begin
                if (last_step) begin
                    state_next = S_TICK_OUT;
                end
            end
            S_TICK_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_COUNT: begin
                if (last_step) begin
                    state_next = (found_step == '0) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_now && out_free && k_inc == found_reg) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            threshold_reg  <= THRESHOLD_RST;
            esc_base_reg   <= ESC_BASE_RST;
            esc_count_reg  <= ESC_COUNT_RST;
            active_vcs_reg <= ACTIVE_VCS_RST;
            for (int i = 0; i < NUM_VC; i++) begin
                count_mem[i] <= '0;
            end
            flag_mask_reg  <= '0;
            tick_total_reg <= '0;
            det_total_reg  <= '0;
            rec_total_reg  <= '0;
            idx_reg        <= '0;
            found_reg      <= '0;
            k_reg          <= '0;
            rem_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_THRESHOLD:  threshold_reg  <= cfg_wdata[15:0];
                    REG_ESC_BASE:   esc_base_reg   <= cfg_wdata[4:0];
                    REG_ESC_COUNT:  esc_count_reg  <= cfg_wdata[4:0];
                    REG_ACTIVE_VCS: active_vcs_reg <= cfg_wdata[4:0];
                endcase
            end

            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    idx_reg   <= '0;
                    wmask_reg <= s_tdata;
                    if (s_tvalid) begin
                        if (s_tuser == CMD_TICK) begin
                            tick_total_reg <= tick_total_reg + 32'd1;
                        end else begin
                            // Recovery clears every flag, active or not.
                            scan_reg      <= flag_mask_reg;
                            flag_mask_reg <= '0;
                            found_reg     <= '0;
                        end
                    end
                end
                S_TICK: begin
                    if (ch_active) begin
                        if (ch_wait) begin
                            count_mem[ch] <= inc_count;
                            if (hit) begin
                                flag_mask_reg[ch] <= 1'b1;
                            end
                        end else begin
                            count_mem[ch] <= '0;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_TICK_OUT: begin
                    if (out_free) begin
                        det_total_reg                <= det_inc;
                        result_reg.pad               <= '0;
                        result_reg.recovered_total   <= rec_total_reg;
                        result_reg.detected_total    <= det_inc;
                        result_reg.tick_total        <= tick_total_reg;
                        result_reg.recovered_count   <= '0;
                        result_reg.escape_valid      <= 1'b0;
                        result_reg.escape_chan       <= '0;
                        result_reg.vc_index          <= '0;
                        result_reg.deadlock_present  <= flag_mask_reg != '0;
                        result_reg.deadlock_mask     <= 16'(flag_mask_reg);
                        m_tlast_reg                  <= 1'b1;
                    end
                end
                S_COUNT: begin
                    found_reg <= found_step;
                    if (last_step) begin
                        idx_reg       <= '0;
                        rem_reg       <= '0;
                        k_reg         <= '0;
                        rec_total_reg <= rec_total_reg + 32'(found_step);
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!emit_now || out_free) begin
                        idx_reg <= idx_reg + 1'b1;
                        rem_reg <= rem_next;
                    end
                    if (emit_now && out_free) begin
                        count_mem[ch]                <= '0;
                        k_reg                        <= k_inc;
                        result_reg.pad               <= '0;
                        result_reg.recovered_total   <= rec_total_reg;
                        result_reg.detected_total    <= det_total_reg;
                        result_reg.tick_total        <= tick_total_reg;
                        result_reg.recovered_count   <= 5'(k_inc);
                        result_reg.escape_valid      <= esc_vc < eff_n;
                        result_reg.escape_chan       <= esc_vc;
                        result_reg.vc_index          <= idx6[3:0];
                        result_reg.deadlock_present  <= 1'b0;
                        result_reg.deadlock_mask     <= '0;
                        m_tlast_reg                  <= k_inc == found_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = result_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[hdl/vcdd_checker.sv]
module vcdd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tlast
);

    // A stalled result holds still.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

    // An accepted request takes the block out of the idle state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted on back-to-back cycles");

    // The present flag always agrees with the mask it summarizes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16] == (m_tdata[15:0] != 16'd0))
    else $error("deadlock_present disagrees with deadlock_mask");

    // Recovery results report the flags already cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32:28] != 5'd0 |-> m_tdata[15:0] == 16'd0)
    else $error("recovery result shows flags still set");

endmodule

bind vc_deadlock_timeout_detector_core vcdd_checker u_vcdd_checker (.*);

[tb/tb_vc_deadlock_timeout_detector_core.sv]
module tb_vc_deadlock_timeout_detector_core;
    import vcdd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VC       = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam int QUIET_CYCLES = 2 * NUM_VC + 8;
    localparam int RANDOM_ITEMS = 120;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct {
        result_t fields;
        logic    last;
    } status_report_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [WMASK_W-1:0]     s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Local copy of the detector state and its registers.
    logic [COUNT_WIDTH-1:0] wait_ticks [NUM_VC];
    logic [15:0]            stuck_flags;
    logic [31:0]            tick_seen;
    logic [31:0]            detect_seen;
    logic [31:0]            recover_seen;
    logic [15:0]            cur_threshold;
    logic [4:0]             cur_esc_base;
    logic [4:0]             cur_esc_count;
    logic [4:0]             cur_active;

    status_report_t pending_reports [$];
    int             mismatch_count;
    bit             quiet_phase;

    vc_deadlock_timeout_detector_core #(
        .NUM_VC      (NUM_VC),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    function automatic void queue_report(input int vc, input int esc, input bit esc_ok,
                                         input int count, input bit last);
        status_report_t rep;
        rep.fields                  = '0;
        rep.fields.deadlock_mask    = stuck_flags;
        rep.fields.deadlock_present = (stuck_flags != 16'd0);
        rep.fields.vc_index         = 4'(vc);
        rep.fields.escape_chan      = 6'(esc);
        rep.fields.escape_valid     = esc_ok;
        rep.fields.recovered_count  = 5'(count);
        rep.fields.tick_total       = tick_seen;
        rep.fields.detected_total   = detect_seen;
        rep.fields.recovered_total  = recover_seen;
        rep.last                    = last;
        pending_reports.push_back(rep);
    endfunction

    function automatic void advance_detector(input logic cmd, input logic [15:0] waiting);
        int n;
        int divisor;
        int found;
        int vcs [NUM_VC];
        int escs [NUM_VC];
        n = (cur_active > NUM_VC) ? NUM_VC : int'(cur_active);
        if (cmd == CMD_TICK) begin
            tick_seen++;
            for (int i = 0; i < n; i++) begin
                if (waiting[i]) begin
                    if (wait_ticks[i] != COUNT_MAX) wait_ticks[i]++;
                    if (wait_ticks[i] >= cur_threshold) stuck_flags[i] = 1'b1;
                end else begin
                    wait_ticks[i] = '0;
                end
            end
            if (stuck_flags != 16'd0) detect_seen++;
            queue_report(0, 0, 1'b0, 0, 1'b1);
        end else begin
            divisor = (cur_esc_count == 5'd0) ? 1 : int'(cur_esc_count);
            found = 0;
            for (int i = 0; i < n; i++) begin
                if (stuck_flags[i]) begin
                    vcs[found]  = i;
                    escs[found] = int'(cur_esc_base) + (i % divisor);
                    wait_ticks[i] = '0;
                    found++;
                end
            end
            // Flags of channels outside the active range go away silently.
            stuck_flags = 16'd0;
            recover_seen += 32'(found);
            for (int k = 0; k < found; k++) begin
                queue_report(vcs[k], escs[k], escs[k] < n, k + 1, k + 1 == found);
            end
        end
    endfunction

    // Lowers the request line and waits until the block has gone quiet.
    task automatic wait_results_done(input int settle);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_THRESHOLD:  cur_threshold = value;
            REG_ESC_BASE:   cur_esc_base  = value[4:0];
            REG_ESC_COUNT:  cur_esc_count = value[4:0];
            REG_ACTIVE_VCS: cur_active    = value[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] threshold, input logic [4:0] esc_base,
                              input logic [4:0] esc_count, input logic [4:0] active);
        wait_results_done(QUIET_CYCLES);
        write_reg(REG_THRESHOLD, threshold);
        write_reg(REG_ESC_BASE, 16'(esc_base));
        write_reg(REG_ESC_COUNT, 16'(esc_count));
        write_reg(REG_ACTIVE_VCS, 16'(active));
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(input logic cmd, input logic [15:0] waiting);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= waiting;
        do @(posedge aclk); while (s_tready !== 1'b1);
        advance_detector(cmd, waiting);
    endtask

    task automatic test_default_config();
        send_request(CMD_TICK, 16'hFFFF);
        send_request(CMD_TICK, 16'h0000);
        send_request(CMD_TICK, 16'hAAAA);
        // Nothing is flagged under the reset threshold, so this recover is silent.
        send_request(CMD_RECOVER, 16'h5555);
    endtask

    task automatic test_timeout_and_recovery();
        set_config(16'd2, 5'd3, 5'd4, 5'd16);
        send_request(CMD_TICK, 16'hFFFF);
        send_request(CMD_TICK, 16'hFFFF);
        send_request(CMD_TICK, 16'h5555);
        send_request(CMD_RECOVER, 16'h0000);
    endtask

    task automatic test_escape_corners();
        // Zero threshold, zero escape count and an oversized active count.
        set_config(16'd0, 5'd31, 5'd0, 5'd31);
        send_request(CMD_TICK, 16'h8001);
        send_request(CMD_RECOVER, 16'hFFFF);
        // Escape channels run past the active range and come back invalid.
        set_config(16'd1, 5'd31, 5'd31, 5'd16);
        send_request(CMD_TICK, 16'hFFFF);
        send_request(CMD_RECOVER, 16'h0000);
    endtask

    task automatic test_inactive_channels();
        set_config(16'd1, 5'd0, 5'd16, 5'd16);
        send_request(CMD_TICK, 16'hFFFF);
        set_config(16'd1, 5'd0, 5'd16, 5'd4);
        send_request(CMD_TICK, 16'h0000);
        send_request(CMD_RECOVER, 16'h0000);
        send_request(CMD_TICK, 16'hFFFF);
        set_config(16'd1, 5'd2, 5'd3, 5'd0);
        send_request(CMD_TICK, 16'hFFFF);
        send_request(CMD_RECOVER, 16'hFFFF);
        set_config(16'hFFFF, 5'd0, 5'd1, 5'd16);
        send_request(CMD_TICK, 16'hFFFF);
        send_request(CMD_RECOVER, 16'h0000);
    endtask

    task automatic random_config();
        logic [15:0] threshold;
        logic [4:0]  esc_base;
        logic [4:0]  esc_count;
        logic [4:0]  active;
        case ($urandom_range(0, 7))
            0:       threshold = 16'd0;
            1:       threshold = 16'hFFFF;
            2:       threshold = 16'($urandom);
            default: threshold = 16'($urandom_range(1, 6));
        endcase
        esc_base  = 5'($urandom_range(0, 31));
        esc_count = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 16));
        active    = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 16));
        set_config(threshold, esc_base, esc_count, active);
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase;
        int len;
        logic [15:0] pattern;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            random_config();
            quiet_phase = (phase % 4 == 3);
            repeat ($urandom_range(2, 4)) begin
                // A steady waiting pattern with sparse flips lets counters run out.
                pattern = 16'($urandom);
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    send_request(CMD_TICK,
                                 pattern ^ (16'($urandom) & 16'($urandom) & 16'($urandom)));
                    sent++;
                end
                if ($urandom_range(0, 9) < 8) begin
                    send_request(CMD_RECOVER, 16'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_request(1'($urandom), 16'($urandom));
                    sent++;
                end
            end
            if (phase == 2) wait_results_done(1);
            phase++;
        end
        quiet_phase = 1'b0;
    endtask

    always @(posedge aclk) begin
        status_report_t want;
        result_t        got;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("result arrived with no request outstanding");
            end else begin
                want = pending_reports.pop_front();
                got  = result_t'(m_tdata);
                check_field("deadlock_mask", 32'(got.deadlock_mask),
                            32'(want.fields.deadlock_mask));
                check_field("deadlock_present", 32'(got.deadlock_present),
                            32'(want.fields.deadlock_present));
                check_field("vc_index", 32'(got.vc_index), 32'(want.fields.vc_index));
                check_field("escape_chan", 32'(got.escape_chan),
                            32'(want.fields.escape_chan));
                check_field("escape_valid", 32'(got.escape_valid),
                            32'(want.fields.escape_valid));
                check_field("recovered_count", 32'(got.recovered_count),
                            32'(want.fields.recovered_count));
                check_field("tick_total", got.tick_total, want.fields.tick_total);
                check_field("detected_total", got.detected_total,
                            want.fields.detected_total);
                check_field("recovered_total", got.recovered_total,
                            want.fields.recovered_total);
                check_field("pad", 32'(got.pad), 32'd0);
                check_field("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // Receiver side: a fresh random stall before every result, none in quiet phases.
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    initial begin
        #5000000;
        $display("tb_vc_deadlock_timeout_detector_core NOT OK");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_TICK;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_THRESHOLD;
        cfg_wdata <= '0;
        mismatch_count = 0;
        quiet_phase    = 1'b0;
        for (int i = 0; i < NUM_VC; i++) wait_ticks[i] = '0;
        stuck_flags   = 16'd0;
        tick_seen     = 32'd0;
        detect_seen   = 32'd0;
        recover_seen  = 32'd0;
        cur_threshold = THRESHOLD_RST;
        cur_esc_base  = ESC_BASE_RST;
        cur_esc_count = ESC_COUNT_RST;
        cur_active    = ACTIVE_VCS_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_config();
        test_timeout_and_recovery();
        test_escape_corners();
        test_inactive_channels();
        test_random_traffic();

        wait_results_done(QUIET_CYCLES);
        if (mismatch_count == 0) begin
            $display("tb_vc_deadlock_timeout_detector_core OK");
        end else begin
            $display("tb_vc_deadlock_timeout_detector_core NOT OK");
        end
        $finish;
    end

endmodule
